@@ hw/rtl/utf8_to_utf16_decoder_assert.svh @@
// Assertion macros for the UTF-8 to UTF-16 decoder top level.
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define U8U16_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8U16_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/u8u16_pkg.sv @@
// Types and constants of the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package u8u16_pkg;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
	localparam logic [15:0]     SURR_HIGH = 16'hD800;
	localparam logic [15:0]     SURR_LOW  = 16'hDC00;

	// continuation bytes still awaited, held in the pending-byte counter
	localparam logic [1:0] NEED_NONE  = 2'd0;
	localparam logic [1:0] NEED_ONE   = 2'd1;
	localparam logic [1:0] NEED_TWO   = 2'd2;
	localparam logic [1:0] NEED_THREE = 2'd3;

	// one complete code point waiting for the back end
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            pair;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

@@ hw/rtl/u8u16_if.sv @@
// Valid/ready channel interfaces for bytes in and UTF-16 words out.
`timescale 1ns / 1ps

interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_of_run;

	modport source (output valid, output code_unit, output last_of_run, input ready);
	modport sink (input valid, input code_unit, input last_of_run, output ready);
endinterface

@@ hw/rtl/u8u16_fifo.sv @@
// Small job queue between the decoder front and back ends.
`timescale 1ns / 1ps

module u8u16_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8u16_pkg::job_t     push_job,
	input  logic                pop,
	output u8u16_pkg::job_t     head,
	output u8u16_pkg::fifo_stat_t stat
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	u8u16_pkg::job_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = (cnt_q == FULL_CNT);
	assign stat.empty = (cnt_q == '0);

endmodule

@@ hw/rtl/u8u16_front.sv @@
// Front end: takes bytes, tracks the pending sequence, queues complete code points.
`timescale 1ns / 1ps

module u8u16_front (
	input  logic                  clk,
	input  logic                  arst_n,
	u8u16_byte_if.sink            bytes,
	input  u8u16_pkg::fifo_stat_t stat,
	output logic                  push,
	output u8u16_pkg::job_t       job
);

	logic [u8u16_pkg::CP_W-1:0] pcp_q;
	logic [u8u16_pkg::CP_W-1:0] pcp_d;
	logic [1:0]                 need_q;
	logic [1:0]                 need_d;
	logic [u8u16_pkg::CP_W-1:0] cp;
	logic                       emit;
	logic                       accept;

	assign bytes.ready = !stat.full;
	assign accept      = bytes.valid && bytes.ready;

	always_comb begin
		pcp_d  = pcp_q;
		need_d = need_q;
		emit   = 1'b0;
		cp     = {13'd0, bytes.in_byte};
		if (need_q == u8u16_pkg::NEED_NONE) begin
			unique casez (bytes.in_byte)
				8'b0???????: begin
					emit = 1'b1;
				end
				8'b110?????: begin
					pcp_d  = {16'd0, bytes.in_byte[4:0]};
					need_d = u8u16_pkg::NEED_ONE;
				end
				8'b1110????: begin
					pcp_d  = {17'd0, bytes.in_byte[3:0]};
					need_d = u8u16_pkg::NEED_TWO;
				end
				8'b11110???: begin
					pcp_d  = {18'd0, bytes.in_byte[2:0]};
					need_d = u8u16_pkg::NEED_THREE;
				end
				default: begin
					// stray byte: drop
				end
			endcase
		end else begin
			// any byte counts as a continuation here
			cp     = {pcp_q[14:0], bytes.in_byte[5:0]};
			pcp_d  = cp;
			need_d = need_q - 2'd1;
			if (need_q == u8u16_pkg::NEED_ONE) begin
				emit  = 1'b1;
				pcp_d = '0;
			end
		end
		if (bytes.end_of_string) begin
			pcp_d  = '0;
			need_d = u8u16_pkg::NEED_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcp_q  <= '0;
			need_q <= u8u16_pkg::NEED_NONE;
		end else if (accept) begin
			pcp_q  <= pcp_d;
			need_q <= need_d;
		end
	end

	assign push           = accept && emit;
	assign job.code_point = cp;
	assign job.pair       = |cp[20:16];

endmodule

@@ hw/rtl/u8u16_back.sv @@
// Back end: turns queued code points into one or two UTF-16 words.
`timescale 1ns / 1ps

module u8u16_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  u8u16_pkg::job_t       head,
	input  u8u16_pkg::fifo_stat_t stat,
	output logic                  pop,
	u8u16_unit_if.source          units
);

	logic                       valid_q;
	logic [15:0]                unit_q;
	logic                       last_q;
	logic                       second_q;
	logic                       load;
	logic [u8u16_pkg::CP_W-1:0] v;
	logic [15:0]                high_w;
	logic [15:0]                low_w;

	assign v      = head.code_point - u8u16_pkg::SUPP_BASE;
	assign high_w = u8u16_pkg::SURR_HIGH | {5'd0, v[20:10]};
	assign low_w  = u8u16_pkg::SURR_LOW | {6'd0, v[9:0]};

	assign load = !valid_q || units.ready;
	assign pop  = load && !stat.empty && (!head.pair || second_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= !stat.empty;
			if (!stat.empty) begin
				second_q <= head.pair && !second_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !stat.empty) begin
			if (head.pair && !second_q) begin
				unit_q <= high_w;
				last_q <= 1'b0;
			end else begin
				unit_q <= head.pair ? low_w : head.code_point[15:0];
				last_q <= 1'b1;
			end
		end
	end

	assign units.valid       = valid_q;
	assign units.code_unit   = unit_q;
	assign units.last_of_run = last_q;

endmodule

@@ hw/rtl/utf8_to_utf16_decoder.sv @@
// A byte that completes a code point is pushed into the job queue when it is accepted; its
//   first word is then loaded from the queue head into the output register.
// Throughput: one byte per cycle while the queue has room; a code point at or above 0x10000
//   holds the head for its high then low surrogate; one word per cycle out while ready.
// The input stalls while the job queue (QUEUE_DEPTH code points) is full.
// Reset (arst_n low) clears the pending sequence, the queue and the output valid.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input logic          clk,
	input logic          arst_n,
	u8u16_byte_if.sink   bytes,
	u8u16_unit_if.source units
);

	`include "utf8_to_utf16_decoder_assert.svh"

	// front to queue
	logic                  push;
	u8u16_pkg::job_t       push_job;
	// queue to back
	logic                  pop;
	u8u16_pkg::job_t       head;
	u8u16_pkg::fifo_stat_t stat;

	// Front: accept a byte each cycle the queue has room, gather the
	// code point and push it once the sequence is complete.
	u8u16_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.stat   (stat),
		.push   (push),
		.job    (push_job)
	);

	// Queue: decouple byte intake from word output.
	u8u16_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	// Back: drive the output register; hold a pair job at the head until
	// its low surrogate word has been loaded.
	u8u16_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.units  (units)
	);

	// A high word may run past 0xDBFF for code points above 0x10FFFF, so check
	// only the 0xD800 to 0xDFFF band here.
	`U8U16_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !stat.full, "push into full queue")
	`U8U16_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !stat.empty, "pop from empty queue")
	`U8U16_ASSERT_IMP(a_mid_is_high, clk, arst_n, units.valid && !units.last_of_run,
		units.code_unit[15:11] == 5'b11011, "non-final word is not a high surrogate")
	`U8U16_ASSERT_NXT(a_low_follows, clk, arst_n,
		units.valid && units.ready && !units.last_of_run,
		units.valid && units.last_of_run && units.code_unit[15:10] == 6'b110111,
		"low surrogate does not follow high surrogate")

endmodule
